FILE: rtl/ndrm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ndrm_pkg;

    localparam int STORE_DEPTH  = 4096;
    localparam int VALUE_WIDTH  = 32;
    localparam int MAX_DIMS     = 4;
    localparam int INDEX_FIELDS = 4;
    localparam int USED_DIMS    = (MAX_DIMS < INDEX_FIELDS) ? MAX_DIMS : INDEX_FIELDS;

    localparam int ADDR_W     = $clog2(STORE_DEPTH);
    localparam int INDEX_W    = 12;
    localparam int SIZE_W     = 13;
    localparam int COUNT_W    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int DIM_IDX_W  = $clog2(INDEX_FIELDS);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DIM_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_DIM0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_DIM1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_DIM2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_DIM3 = 3'd4;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // effective shape: dims already clamped to 1..USED_DIMS
    typedef struct packed {
        logic [COUNT_W-1:0]                   dims;
        logic [INDEX_FIELDS-1:0][SIZE_W-1:0]  size;
    } cfg_t;

    typedef struct packed {
        logic              fail;
        logic [ADDR_W-1:0] addr;
    } addr_res_t;

endpackage

`default_nettype wire

FILE: rtl/ndrm_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module ndrm_cfg_regs (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  cfg_wr_en,
    input  wire  [ndrm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire  [ndrm_pkg::CFG_DATA_W-1:0]      cfg_data,
    output ndrm_pkg::cfg_t                       cfg
);

    logic [ndrm_pkg::COUNT_W-1:0] dim_count_reg;
    logic [ndrm_pkg::INDEX_FIELDS-1:0][ndrm_pkg::SIZE_W-1:0] size_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dim_count_reg <= ndrm_pkg::COUNT_W'(1);
            for (int i = 0; i < ndrm_pkg::INDEX_FIELDS; i++) begin
                size_reg[i] <= ndrm_pkg::SIZE_W'(1);
            end
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                ndrm_pkg::REG_DIM_COUNT: dim_count_reg <= cfg_data[ndrm_pkg::COUNT_W-1:0];
                ndrm_pkg::REG_SIZE_DIM0: size_reg[0] <= cfg_data[ndrm_pkg::SIZE_W-1:0];
                ndrm_pkg::REG_SIZE_DIM1: size_reg[1] <= cfg_data[ndrm_pkg::SIZE_W-1:0];
                ndrm_pkg::REG_SIZE_DIM2: size_reg[2] <= cfg_data[ndrm_pkg::SIZE_W-1:0];
                ndrm_pkg::REG_SIZE_DIM3: size_reg[3] <= cfg_data[ndrm_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.size = size_reg;
        if (dim_count_reg == '0) begin
            cfg.dims = ndrm_pkg::COUNT_W'(1);
        end else if (dim_count_reg > ndrm_pkg::COUNT_W'(ndrm_pkg::USED_DIMS)) begin
            cfg.dims = ndrm_pkg::COUNT_W'(ndrm_pkg::USED_DIMS);
        end else begin
            cfg.dims = dim_count_reg;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ndrm_addr_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// One multiply-accumulate per dimension: addr = addr * size[d] + index[d].
// Once the partial address reaches the store depth it can only grow, so the
// accumulator stays narrow and a sticky flag records the overflow.
module ndrm_addr_unit (
    input  wire                                                   aclk,
    input  wire                                                   aresetn,
    input  wire                                                   start,
    input  wire  [ndrm_pkg::INDEX_FIELDS-1:0][ndrm_pkg::INDEX_W-1:0] index,
    input  ndrm_pkg::cfg_t                                        cfg,
    output logic                                                  done,
    output ndrm_pkg::addr_res_t                                   res
);

    localparam int PROD_W = ndrm_pkg::ADDR_W + ndrm_pkg::SIZE_W;
    localparam int SUM_W  = PROD_W + 1;

    logic                              busy_reg;
    logic                              done_reg;
    logic [ndrm_pkg::DIM_IDX_W-1:0]    d_reg;
    logic [ndrm_pkg::ADDR_W-1:0]       acc_reg;
    logic                              bad_reg;
    logic                              big_reg;

    logic [ndrm_pkg::INDEX_W-1:0]      idx_cur;
    logic [ndrm_pkg::SIZE_W-1:0]       sz_cur;
    logic [PROD_W-1:0]                 prod;
    logic [SUM_W-1:0]                  sum;
    logic                              idx_bad;
    logic                              sum_big;
    logic                              last;

    assign idx_cur = index[d_reg];
    assign sz_cur  = cfg.size[d_reg];
    assign prod    = {{ndrm_pkg::SIZE_W{1'b0}}, acc_reg} * {{ndrm_pkg::ADDR_W{1'b0}}, sz_cur};
    assign sum     = {1'b0, prod} + {{(SUM_W - ndrm_pkg::INDEX_W){1'b0}}, idx_cur};
    assign idx_bad = {1'b0, idx_cur} >= sz_cur;
    assign sum_big = sum >= SUM_W'(ndrm_pkg::STORE_DEPTH);
    assign last    = ndrm_pkg::COUNT_W'(d_reg) == (cfg.dims - ndrm_pkg::COUNT_W'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            d_reg    <= '0;
            acc_reg  <= '0;
            bad_reg  <= 1'b0;
            big_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                d_reg    <= '0;
                acc_reg  <= '0;
                bad_reg  <= 1'b0;
                big_reg  <= 1'b0;
            end else if (busy_reg) begin
                acc_reg <= sum[ndrm_pkg::ADDR_W-1:0];
                bad_reg <= bad_reg | idx_bad;
                big_reg <= big_reg | sum_big;
                d_reg   <= d_reg + ndrm_pkg::DIM_IDX_W'(1);
                if (last) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign res.fail = bad_reg | big_reg;
    assign res.addr = acc_reg;

endmodule

`default_nettype wire

FILE: rtl/ndrm_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ndrm_ram (
    input  wire                                  aclk,
    input  wire                                  en,
    input  wire                                  we,
    input  wire  [ndrm_pkg::ADDR_W-1:0]          addr,
    input  wire  [ndrm_pkg::VALUE_WIDTH-1:0]     wdata,
    output logic [ndrm_pkg::VALUE_WIDTH-1:0]     rdata
);

    logic [ndrm_pkg::VALUE_WIDTH-1:0] mem [ndrm_pkg::STORE_DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/nd_array_row_major_store.sv
`timescale 1ns / 1ps
`default_nettype none

// Row-major N-dimensional element store, 4096 x 32-bit, single-port RAM.
// After reset the RAM is swept to zero, one entry per cycle; s_ready stays
// low during the sweep, configuration writes are taken at any time. Each
// request is a read or a write with up to four indices; the address unit
// does one multiply-accumulate per dimension in use, then the RAM is
// accessed, then the result is loaded into the output register. s_ready is
// low from acceptance until that load and rises with it, so a new request
// is not accepted before the current one's result is loaded. Any index at
// or beyond its extent, or a linear address at or beyond the depth, returns
// status 1 with read_value 0 and leaves the store untouched. Writes return
// read_value 0. A result held in the output register does not block the next
// request until that request's own result is ready; while the held result
// waits on m_ready after that, the new result waits in ST_RESP.
module nd_array_row_major_store (
    input  wire                                  aclk,
    input  wire                                  aresetn,

    input  wire                                  cfg_wr_en,
    input  wire  [ndrm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire  [ndrm_pkg::CFG_DATA_W-1:0]      cfg_data,

    input  wire                                  s_valid,
    output logic                                 s_ready,
    input  wire                                  s_command,
    input  wire  [ndrm_pkg::INDEX_W-1:0]         s_index0,
    input  wire  [ndrm_pkg::INDEX_W-1:0]         s_index1,
    input  wire  [ndrm_pkg::INDEX_W-1:0]         s_index2,
    input  wire  [ndrm_pkg::INDEX_W-1:0]         s_index3,
    input  wire  [ndrm_pkg::VALUE_WIDTH-1:0]     s_write_value,

    output logic                                 m_valid,
    input  wire                                  m_ready,
    output logic [ndrm_pkg::VALUE_WIDTH-1:0]     m_read_value,
    output logic                                 m_status
);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_CALC  = 4'b0100,
        ST_RESP  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [ndrm_pkg::ADDR_W-1:0]       clr_cnt_reg, clr_cnt_next;
    logic                              cmd_reg;
    logic [ndrm_pkg::INDEX_FIELDS-1:0][ndrm_pkg::INDEX_W-1:0] idx_reg;
    logic [ndrm_pkg::VALUE_WIDTH-1:0]  wval_reg;

    logic                              m_valid_reg, m_valid_next;
    logic [ndrm_pkg::VALUE_WIDTH-1:0]  m_read_value_reg, m_read_value_next;
    logic                              m_status_reg, m_status_next;

    ndrm_pkg::cfg_t                    cfg;
    ndrm_pkg::addr_res_t               addr_res;
    logic                              addr_done;
    logic                              accept;

    logic                              ram_en;
    logic                              ram_we;
    logic [ndrm_pkg::ADDR_W-1:0]       ram_addr;
    logic [ndrm_pkg::VALUE_WIDTH-1:0]  ram_wdata;
    logic [ndrm_pkg::VALUE_WIDTH-1:0]  ram_rdata;
    logic                              out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid & s_ready;
    assign out_free = !m_valid_reg || m_ready;

    ndrm_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ndrm_addr_unit u_addr (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .index   (idx_reg),
        .cfg     (cfg),
        .done    (addr_done),
        .res     (addr_res)
    );

    ndrm_ram u_ram (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // indices are latched on the accepting edge; the address unit starts
    // stepping on the following cycle, when idx_reg already holds them
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg    <= s_command;
            idx_reg[0] <= s_index0;
            idx_reg[1] <= s_index1;
            idx_reg[2] <= s_index2;
            idx_reg[3] <= s_index3;
            wval_reg   <= s_write_value;
        end
    end

    always_comb begin
        ram_en    = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = addr_res.addr;
        ram_wdata = wval_reg;
        if (state_reg == ST_CLEAR) begin
            ram_en    = 1'b1;
            ram_we    = 1'b1;
            ram_addr  = clr_cnt_reg;
            ram_wdata = '0;
        end else if (state_reg == ST_CALC && addr_done && !addr_res.fail) begin
            ram_en = 1'b1;
            ram_we = (cmd_reg == ndrm_pkg::CMD_WRITE);
        end
    end

    always_comb begin
        state_next        = state_reg;
        clr_cnt_next      = clr_cnt_reg;
        m_valid_next      = m_valid_reg;
        m_read_value_next = m_read_value_reg;
        m_status_next     = m_status_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + ndrm_pkg::ADDR_W'(1);
                if (clr_cnt_reg == ndrm_pkg::ADDR_W'(ndrm_pkg::STORE_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                if (addr_done) begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                // RAM read data is held while the output register is busy
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = addr_res.fail;
                    if (addr_res.fail || cmd_reg == ndrm_pkg::CMD_WRITE) begin
                        m_read_value_next = '0;
                    end else begin
                        m_read_value_next = ram_rdata;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_read_value_reg <= m_read_value_next;
        m_status_reg     <= m_status_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_read_value = m_read_value_reg;
    assign m_status     = m_status_reg;

    a_result_from_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_RESP))
        else $error("result appeared outside the response state");

    a_fail_zero_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status) |-> (m_read_value == '0))
        else $error("failed request returned a nonzero value");

    a_done_in_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        addr_done |-> (state_reg == ST_CALC))
        else $error("address unit finished with no request pending");

    a_no_write_on_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_en && ram_we && state_reg != ST_CLEAR) |-> !addr_res.fail)
        else $error("store written by an out-of-bound request");

endmodule

`default_nettype wire
